// ===== hdl/serial_eeprom_read_master_assert.svh =====
// Assertion macros shared by the serial EEPROM read master RTL.
`ifndef SERIAL_EEPROM_READ_MASTER_ASSERT_SVH
`define SERIAL_EEPROM_READ_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sem_pkg.sv =====
// Package: types and constants of the serial EEPROM read master.
package sem_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_TX_SET   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_TX_HI    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_TX_HOLD1 = 4'd3;
    localparam logic [PHASE_W-1:0] PH_TX_LO    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_TX_HOLD2 = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RX_HI    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RX_HOLD1 = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RX_LO    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RX_HOLD2 = 4'd9;
    localparam logic [PHASE_W-1:0] PH_END      = 4'd10;
    localparam logic [PHASE_W-1:0] PH_END_HOLD = 4'd11;

    localparam int BIT_CNT_W  = 5;
    localparam int HOLD_W     = 8;
    localparam int WCOUNT_W   = 7;
    localparam int WORD_W     = 16;
    localparam int WADDR_W    = 6;

    // start bit + two opcode bits
    localparam logic [BIT_CNT_W-1:0] CMD_BITS  = 5'd3;
    localparam logic [BIT_CNT_W-1:0] OPC_ONES  = 5'd2;
    localparam logic [BIT_CNT_W-1:0] DATA_LAST = 5'd15;

    localparam logic [0:0] CFG_WORD_COUNT  = 1'b0;
    localparam logic [0:0] CFG_DELAY_TICKS = 1'b1;

    localparam logic [WCOUNT_W-1:0] WORD_COUNT_RST  = 7'd64;
    localparam logic [HOLD_W-1:0]   DELAY_TICKS_RST = 8'd27;

    typedef struct packed {
        logic rom_data_out;
        logic start_req;
    } in_item_t;

    typedef struct packed {
        logic                busy_res;
        logic                read_error;
        logic                last_word;
        logic [WADDR_W-1:0]  word_address;
        logic [WORD_W-1:0]   word_data;
        logic                word_valid;
        logic                rom_data_in;
        logic                serial_clock;
        logic                chip_select;
    } result_t;

endpackage

// ===== hdl/sem_in_reg.sv =====
// Input register stage of the serial EEPROM read master.
module sem_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sem_pkg::in_item_t s_item,
    input  logic              adv,
    output logic              in_valid,
    output sem_pkg::in_item_t in_item
);

    logic              valid_reg;
    logic              valid_next;
    sem_pkg::in_item_t item_reg;

    assign s_tready   = !valid_reg || adv;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

// ===== hdl/sem_seq.sv =====
// Pin sequencer: state registers and one-tick next-state and result logic.
module sem_seq
#(
    parameter int ADDR_BITS = 6,
    parameter int ROM_WORDS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  sem_pkg::in_item_t              item,
    input  logic [sem_pkg::WCOUNT_W-1:0]   word_count,
    input  logic [sem_pkg::HOLD_W-1:0]     delay_ticks,
    output sem_pkg::result_t               result
);

    localparam int AIDX_W = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;
    localparam logic [sem_pkg::BIT_CNT_W-1:0] LAST_TX =
        sem_pkg::BIT_CNT_W'(3 + ADDR_BITS - 1);
    localparam logic [sem_pkg::BIT_CNT_W-1:0] ADDR_TOP =
        sem_pkg::BIT_CNT_W'(ADDR_BITS - 1);
    localparam logic [sem_pkg::BIT_CNT_W-1:0] ADDR_LEN =
        sem_pkg::BIT_CNT_W'(ADDR_BITS);

    logic [sem_pkg::PHASE_W-1:0]   phase_reg,  phase_next;
    logic [sem_pkg::HOLD_W-1:0]    hold_reg,   hold_next;
    logic [sem_pkg::BIT_CNT_W-1:0] bit_reg,    bit_next;
    logic [sem_pkg::WCOUNT_W-1:0]  wcnt_reg,   wcnt_next;
    logic [sem_pkg::WORD_W-1:0]    shift_reg,  shift_next;

    logic [sem_pkg::PHASE_W-1:0]   cur_ph;
    logic [sem_pkg::BIT_CNT_W-1:0] cur_bit;
    logic [sem_pkg::WCOUNT_W-1:0]  cur_wcnt;
    logic [sem_pkg::HOLD_W:0]      hold_inc;
    logic [sem_pkg::HOLD_W-1:0]    hold_len;
    logic                          hold_hit;
    logic [sem_pkg::WCOUNT_W-1:0]  wcnt_inc;
    logic                          tx_din;
    logic [ADDR_BITS-1:0]          addr_vec;
    logic [sem_pkg::BIT_CNT_W-1:0] addr_pos;
    logic [sem_pkg::BIT_CNT_W-1:0] addr_sh;

    // bit to send at position cur_bit: start, opcode, then address MSB first
    always_comb
    begin
        addr_vec = ADDR_BITS'(cur_wcnt);
        addr_pos = cur_bit - sem_pkg::CMD_BITS;
        addr_sh  = ADDR_TOP - addr_pos;
        if (cur_bit < sem_pkg::CMD_BITS)
        begin
            tx_din = (cur_bit < sem_pkg::OPC_ONES);
        end
        else if (addr_pos >= ADDR_LEN)
        begin
            tx_din = 1'b0;
        end
        else
        begin
            tx_din = addr_vec[addr_sh[AIDX_W-1:0]];
        end
    end

    assign hold_len = (delay_ticks == '0) ? sem_pkg::HOLD_W'(1) : delay_ticks;
    assign hold_inc = {1'b0, hold_reg} + 9'd1;
    assign hold_hit = hold_inc >= {1'b0, hold_len};
    assign wcnt_inc = cur_wcnt + 7'd1;

    always_comb
    begin
        cur_ph     = (phase_reg > sem_pkg::PH_END_HOLD) ? sem_pkg::PH_IDLE : phase_reg;
        cur_bit    = bit_reg;
        cur_wcnt   = wcnt_reg;
        hold_next  = hold_reg;
        shift_next = shift_reg;
        result     = '0;

        if (cur_ph == sem_pkg::PH_IDLE && item.start_req)
        begin
            if (int'(word_count) > ROM_WORDS)
            begin
                result.read_error = 1'b1;
            end
            else if (word_count != '0)
            begin
                cur_wcnt   = '0;
                cur_bit    = '0;
                hold_next  = '0;
                shift_next = '0;
                cur_ph     = sem_pkg::PH_TX_SET;
            end
        end

        phase_next = cur_ph;
        bit_next   = cur_bit;
        wcnt_next  = cur_wcnt;

        if (cur_ph != sem_pkg::PH_IDLE)
        begin
            result.busy_res     = 1'b1;
            result.word_address = cur_wcnt[sem_pkg::WADDR_W-1:0];
            result.chip_select  = 1'b1;
        end

        case (cur_ph)
            sem_pkg::PH_TX_SET:
            begin
                result.rom_data_in = tx_din;
                phase_next = sem_pkg::PH_TX_HI;
            end
            sem_pkg::PH_TX_HI:
            begin
                result.rom_data_in  = tx_din;
                result.serial_clock = 1'b1;
                hold_next  = '0;
                phase_next = sem_pkg::PH_TX_HOLD1;
            end
            sem_pkg::PH_TX_HOLD1:
            begin
                result.rom_data_in  = tx_din;
                result.serial_clock = 1'b1;
                hold_next = hold_hit ? '0 : hold_inc[sem_pkg::HOLD_W-1:0];
                if (hold_hit)
                begin
                    phase_next = sem_pkg::PH_TX_LO;
                end
            end
            sem_pkg::PH_TX_LO:
            begin
                result.rom_data_in = tx_din;
                hold_next  = '0;
                phase_next = sem_pkg::PH_TX_HOLD2;
            end
            sem_pkg::PH_TX_HOLD2:
            begin
                result.rom_data_in = tx_din;
                hold_next = hold_hit ? '0 : hold_inc[sem_pkg::HOLD_W-1:0];
                if (hold_hit)
                begin
                    if (cur_bit >= LAST_TX)
                    begin
                        // dummy bit must read low
                        if (item.rom_data_out)
                        begin
                            result.read_error = 1'b1;
                            phase_next = sem_pkg::PH_IDLE;
                        end
                        else
                        begin
                            bit_next   = '0;
                            shift_next = '0;
                            phase_next = sem_pkg::PH_RX_HI;
                        end
                    end
                    else
                    begin
                        bit_next   = cur_bit + 5'd1;
                        phase_next = sem_pkg::PH_TX_SET;
                    end
                end
            end
            sem_pkg::PH_RX_HI:
            begin
                result.serial_clock = 1'b1;
                hold_next  = '0;
                phase_next = sem_pkg::PH_RX_HOLD1;
            end
            sem_pkg::PH_RX_HOLD1:
            begin
                result.serial_clock = 1'b1;
                hold_next = hold_hit ? '0 : hold_inc[sem_pkg::HOLD_W-1:0];
                if (hold_hit)
                begin
                    shift_next = {shift_reg[sem_pkg::WORD_W-2:0], item.rom_data_out};
                    phase_next = sem_pkg::PH_RX_LO;
                end
            end
            sem_pkg::PH_RX_LO:
            begin
                hold_next  = '0;
                phase_next = sem_pkg::PH_RX_HOLD2;
            end
            sem_pkg::PH_RX_HOLD2:
            begin
                hold_next = hold_hit ? '0 : hold_inc[sem_pkg::HOLD_W-1:0];
                if (hold_hit)
                begin
                    if (cur_bit >= sem_pkg::DATA_LAST)
                    begin
                        phase_next = sem_pkg::PH_END;
                    end
                    else
                    begin
                        bit_next   = cur_bit + 5'd1;
                        phase_next = sem_pkg::PH_RX_HI;
                    end
                end
            end
            sem_pkg::PH_END:
            begin
                result.chip_select = 1'b0;
                result.word_valid  = 1'b1;
                result.word_data   = shift_reg;
                result.last_word   = ({1'b0, cur_wcnt} + 8'd1) >= {1'b0, word_count};
                hold_next  = '0;
                phase_next = sem_pkg::PH_END_HOLD;
            end
            sem_pkg::PH_END_HOLD:
            begin
                result.chip_select = 1'b0;
                hold_next = hold_hit ? '0 : hold_inc[sem_pkg::HOLD_W-1:0];
                if (hold_hit)
                begin
                    wcnt_next  = wcnt_inc;
                    bit_next   = '0;
                    shift_next = '0;
                    phase_next = (wcnt_inc >= word_count) ? sem_pkg::PH_IDLE
                                                          : sem_pkg::PH_TX_SET;
                end
            end
            default:
            begin
                phase_next = sem_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sem_pkg::PH_IDLE;
            hold_reg  <= '0;
            bit_reg   <= '0;
            wcnt_reg  <= '0;
            shift_reg <= '0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            bit_reg   <= bit_next;
            wcnt_reg  <= wcnt_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== hdl/serial_eeprom_read_master.sv =====
// Top level of the three-wire serial EEPROM read master.
//
// Each input item is one tick of the pin sequencer: a start request and the
// sampled EEPROM data-out level. Each item gives exactly one result item with
// the pin levels for that tick (chip select, serial clock, data in) plus word
// status. A start while idle reads words 0 .. word_count-1: per word the
// block sends start bit 1, opcode 10 and ADDR_BITS address bits MSB first,
// checks that the dummy bit reads 0 (else read_error and abort), shifts in 16
// data bits MSB first and presents the word on the tick that drops chip
// select. Clock-high and clock-low levels are each followed by a hold of
// delay_ticks ticks (0 acts as 1). A start with word_count above ROM_WORDS
// gives one read_error item and the block stays idle.
// Rate: one item per clock while m_tready does not hold the output. Path: an
// input register, then the sequencer state update and result logic, which
// loads the result register. The result register is freed by m_tready in the
// same cycle, so a stalled output only backs up the input register.
// Configuration writes are always accepted (cfg_ready is high) and are meant
// to be issued while the block is idle.
module serial_eeprom_read_master
#(
    parameter int ADDR_BITS = 6,
    parameter int ROM_WORDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] start_req, [1] rom_data_out, [7:2] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] chip_select, [1] serial_clock, [2] rom_data_in, [18:3] word_data,
    // [24:19] word_address, [25] read_error, [26] busy_res, [31:27] zero
    output logic [31:0] m_tdata,
    output logic        m_tuser,    // [0] word_valid
    output logic        m_tlast,    // last_word

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,  // 0 word_count, 1 delay_ticks
    input  logic [7:0]  cfg_data
);

`include "serial_eeprom_read_master_assert.svh"

    logic [sem_pkg::WCOUNT_W-1:0] word_count_reg;
    logic [sem_pkg::HOLD_W-1:0]   delay_ticks_reg;

    sem_pkg::in_item_t s_item;
    sem_pkg::in_item_t in_item;
    logic              in_valid;
    logic              adv;
    sem_pkg::result_t  seq_result;
    sem_pkg::result_t  res_reg;
    logic              m_valid_reg;
    logic              m_valid_next;

    assign s_item.start_req    = s_tdata[0];
    assign s_item.rom_data_out = s_tdata[1];

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg  <= sem_pkg::WORD_COUNT_RST;
            delay_ticks_reg <= sem_pkg::DELAY_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sem_pkg::CFG_WORD_COUNT:  word_count_reg  <= cfg_data[sem_pkg::WCOUNT_W-1:0];
                sem_pkg::CFG_DELAY_TICKS: delay_ticks_reg <= cfg_data;
                default:                  word_count_reg  <= word_count_reg;
            endcase
        end
    end

    // one tick advances when the result register is free or draining
    assign adv = in_valid && (!m_valid_reg || m_tready);

    sem_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .adv      (adv),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    sem_seq
    #(
        .ADDR_BITS (ADDR_BITS),
        .ROM_WORDS (ROM_WORDS)
    )
    u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item        (in_item),
        .word_count  (word_count_reg),
        .delay_ticks (delay_ticks_reg),
        .result      (seq_result)
    );

    // result register
    assign m_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= seq_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0,
                       res_reg.busy_res,
                       res_reg.read_error,
                       res_reg.word_address,
                       res_reg.word_data,
                       res_reg.rom_data_in,
                       res_reg.serial_clock,
                       res_reg.chip_select};
    assign m_tuser  = res_reg.word_valid;
    assign m_tlast  = res_reg.last_word;

    // a presented word comes with chip select low, inside a run
    `SEM_ASSERT_NOW(a_word_cs_low, m_valid_reg && res_reg.word_valid,
        !res_reg.chip_select && res_reg.busy_res && !res_reg.read_error,
        "word presented with chip select high or outside a run")

    // input side stalls only behind a stalled, full result register
    `SEM_ASSERT_NOW(a_stall_cause, !s_tready,
        in_valid && m_valid_reg && !m_tready,
        "input stalled without a stalled result")

    // a tick taken by the sequencer always lands in the result register
    `SEM_ASSERT_NEXT(a_adv_lands, adv, m_valid_reg,
        "sequencer tick not presented")

    // last flag only rides on a presented word
    `SEM_ASSERT_NOW(a_last_with_word, m_valid_reg && res_reg.last_word,
        res_reg.word_valid,
        "last flag without a word")

endmodule

// ===== tb/sv/serial_eeprom_read_master_tb.sv =====
// Self-checking testbench for the three-wire serial EEPROM read master.
`timescale 1ns / 1ps

module serial_eeprom_read_master_tb;

    localparam int ADDR_BITS    = 6;
    localparam int ROM_WORDS    = 64;
    // bit index of the final address bit; the dummy bit is sampled after it
    localparam int LAST_TX      = int'(sem_pkg::CMD_BITS) + ADDR_BITS - 1;
    localparam int TOTAL_ITEMS  = 1050;   // random runs top the item count up to this
    localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int HOLD_OFF_LEN = 300;    // long receiver stall
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;        // [0] start_req, [1] rom_data_out

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // [0] cs, [1] sclk, [2] din, [18:3] data,
                                      // [24:19] address, [25] error, [26] busy
    logic        m_tuser;             // [0] word_valid
    logic        m_tlast;             // last_word

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    serial_eeprom_read_master #(
        .ADDR_BITS (ADDR_BITS),
        .ROM_WORDS (ROM_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // ------------------------------------------------------------------
    // Sequencer shadow: registers and state as they stand after the last
    // accepted item.
    // ------------------------------------------------------------------
    logic [sem_pkg::WCOUNT_W-1:0]  cfg_word_count = sem_pkg::WORD_COUNT_RST;
    logic [sem_pkg::HOLD_W-1:0]    cfg_delay      = sem_pkg::DELAY_TICKS_RST;

    logic [sem_pkg::PHASE_W-1:0]   seq_phase = sem_pkg::PH_IDLE;
    logic [sem_pkg::HOLD_W-1:0]    hold_cnt  = '0;
    logic [sem_pkg::BIT_CNT_W-1:0] bit_cnt   = '0;
    logic [sem_pkg::WCOUNT_W-1:0]  word_cnt  = '0;
    logic [sem_pkg::WORD_W-1:0]    shift_reg = '0;

    sem_pkg::result_t expected_q[$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_seen    = 0;
    int words_presented = 0;
    int errors_flagged  = 0;
    int reg_writes      = 0;
    int quiet_cycles    = 0;

    // stimulus knobs
    bit src_gaps_on     = 1'b1;
    bit sink_gaps_on    = 1'b1;
    int hold_off_cycles = 0;     // nonzero asks the receiver for a long stall
    int fault_word      = -1;    // word whose dummy bit reads back as 1
    int fault_pct       = 0;     // chance of a bad dummy bit on any word

    task automatic flag_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 75)
            return 0;
        if (r < 96)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // Level driven on the EEPROM data-in pin for command/address bit k:
    // start bit and the first opcode bit are 1, then 0, then the address MSB first.
    function automatic logic cmd_addr_bit(input int unsigned k);
        if (k < sem_pkg::CMD_BITS)
            return (k < sem_pkg::OPC_ONES);
        if (k - sem_pkg::CMD_BITS >= ADDR_BITS)
            return 1'b0;
        return word_cnt[ADDR_BITS - 1 - (k - sem_pkg::CMD_BITS)];
    endfunction

    // One tick of a delay; true on its final tick. A delay of 0 lasts one tick.
    function automatic bit hold_elapsed();
        int unsigned len;
        len = (cfg_delay == 0) ? 1 : cfg_delay;
        if (hold_cnt + 1 >= len)
        begin
            hold_cnt = '0;
            return 1'b1;
        end
        hold_cnt = hold_cnt + 1'b1;
        return 1'b0;
    endfunction

    // Advance the shadow sequencer by one tick and give the pin levels and
    // word status expected for it.
    task automatic predict_tick(input logic start, input logic dout,
                                output sem_pkg::result_t r);
        r = '0;
        if (seq_phase > sem_pkg::PH_END_HOLD)
            seq_phase = sem_pkg::PH_IDLE;

        if (seq_phase == sem_pkg::PH_IDLE && start)
        begin
            if (cfg_word_count > ROM_WORDS)
                r.read_error = 1'b1;
            else if (cfg_word_count != 0)
            begin
                word_cnt  = '0;
                bit_cnt   = '0;
                hold_cnt  = '0;
                shift_reg = '0;
                seq_phase = sem_pkg::PH_TX_SET;
            end
        end

        if (seq_phase != sem_pkg::PH_IDLE)
        begin
            r.busy_res     = 1'b1;
            r.word_address = word_cnt[sem_pkg::WADDR_W-1:0];
            r.chip_select  = 1'b1;
            case (seq_phase)
                sem_pkg::PH_TX_SET:
                begin
                    r.rom_data_in = cmd_addr_bit(bit_cnt);
                    seq_phase = sem_pkg::PH_TX_HI;
                end
                sem_pkg::PH_TX_HI:
                begin
                    r.rom_data_in  = cmd_addr_bit(bit_cnt);
                    r.serial_clock = 1'b1;
                    hold_cnt = '0;
                    seq_phase = sem_pkg::PH_TX_HOLD1;
                end
                sem_pkg::PH_TX_HOLD1:
                begin
                    r.rom_data_in  = cmd_addr_bit(bit_cnt);
                    r.serial_clock = 1'b1;
                    if (hold_elapsed())
                        seq_phase = sem_pkg::PH_TX_LO;
                end
                sem_pkg::PH_TX_LO:
                begin
                    r.rom_data_in = cmd_addr_bit(bit_cnt);
                    hold_cnt = '0;
                    seq_phase = sem_pkg::PH_TX_HOLD2;
                end
                sem_pkg::PH_TX_HOLD2:
                begin
                    r.rom_data_in = cmd_addr_bit(bit_cnt);
                    if (hold_elapsed())
                    begin
                        if (bit_cnt >= LAST_TX)
                        begin
                            // dummy bit must read 0, else the run is dropped
                            if (dout)
                            begin
                                r.read_error = 1'b1;
                                seq_phase = sem_pkg::PH_IDLE;
                            end
                            else
                            begin
                                bit_cnt   = '0;
                                shift_reg = '0;
                                seq_phase = sem_pkg::PH_RX_HI;
                            end
                        end
                        else
                        begin
                            bit_cnt   = bit_cnt + 1'b1;
                            seq_phase = sem_pkg::PH_TX_SET;
                        end
                    end
                end
                sem_pkg::PH_RX_HI:
                begin
                    r.serial_clock = 1'b1;
                    hold_cnt = '0;
                    seq_phase = sem_pkg::PH_RX_HOLD1;
                end
                sem_pkg::PH_RX_HOLD1:
                begin
                    r.serial_clock = 1'b1;
                    if (hold_elapsed())
                    begin
                        shift_reg = {shift_reg[sem_pkg::WORD_W-2:0], dout};
                        seq_phase = sem_pkg::PH_RX_LO;
                    end
                end
                sem_pkg::PH_RX_LO:
                begin
                    hold_cnt = '0;
                    seq_phase = sem_pkg::PH_RX_HOLD2;
                end
                sem_pkg::PH_RX_HOLD2:
                begin
                    if (hold_elapsed())
                    begin
                        if (bit_cnt >= sem_pkg::DATA_LAST)
                            seq_phase = sem_pkg::PH_END;
                        else
                        begin
                            bit_cnt   = bit_cnt + 1'b1;
                            seq_phase = sem_pkg::PH_RX_HI;
                        end
                    end
                end
                sem_pkg::PH_END:
                begin
                    r.chip_select = 1'b0;
                    r.word_valid  = 1'b1;
                    r.word_data   = shift_reg;
                    r.last_word   = (int'(word_cnt) + 1 >= int'(cfg_word_count));
                    hold_cnt = '0;
                    seq_phase = sem_pkg::PH_END_HOLD;
                end
                default:
                begin
                    r.chip_select = 1'b0;
                    if (hold_elapsed())
                    begin
                        word_cnt  = word_cnt + 1'b1;
                        bit_cnt   = '0;
                        shift_reg = '0;
                        seq_phase = (word_cnt >= cfg_word_count) ? sem_pkg::PH_IDLE
                                                                 : sem_pkg::PH_TX_SET;
                    end
                end
            endcase
        end

        if (r.word_valid)
            words_presented++;
        if (r.read_error)
            errors_flagged++;
    endtask

    // ------------------------------------------------------------------
    // Sender: one item per call. The data-out pin acts like an EEPROM:
    // random levels, except the dummy bit, which reads 0 unless a fault
    // is asked for on this word.
    // ------------------------------------------------------------------
    task automatic drive_tick(input logic start);
        int               gap;
        logic             dout;
        sem_pkg::result_t r;
        if (seq_phase == sem_pkg::PH_TX_HOLD2 && bit_cnt == LAST_TX)
            dout = (int'(word_cnt) == fault_word) || ($urandom_range(0, 99) < fault_pct);
        else
            dout = 1'($urandom_range(0, 1));
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, dout, start};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tick(start, dout, r);
        expected_q.push_back(r);
        items_sent++;
    endtask

    // Keep ticking until the run in progress is over; starts are ignored meanwhile.
    task automatic finish_run();
        while (seq_phase != sem_pkg::PH_IDLE)
            drive_tick(1'($urandom_range(0, 1)));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Register write, only with every result home and nothing in flight.
    task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == sem_pkg::CFG_WORD_COUNT)
            cfg_word_count = value[sem_pkg::WCOUNT_W-1:0];
        else
            cfg_delay = value;
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                stall_left = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else if (stall_left == 0 && sink_gaps_on)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
            flag_error($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                 results_seen, name, exp_v, got_v));
    endtask

    // Compare every result item with the oldest expectation.
    always @(posedge clk)
    begin
        sem_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
            else
            begin
                want = expected_q.pop_front();
                check_field("chip_select",  32'(want.chip_select),  32'(m_tdata[0]));
                check_field("serial_clock", 32'(want.serial_clock), 32'(m_tdata[1]));
                check_field("rom_data_in",  32'(want.rom_data_in),  32'(m_tdata[2]));
                check_field("word_data",    32'(want.word_data),    32'(m_tdata[18:3]));
                check_field("word_address", 32'(want.word_address), 32'(m_tdata[24:19]));
                check_field("read_error",   32'(want.read_error),   32'(m_tdata[25]));
                check_field("busy_res",     32'(want.busy_res),     32'(m_tdata[26]));
                check_field("word_valid",   32'(want.word_valid),   32'(m_tuser));
                check_field("last_word",    32'(want.last_word),    32'(m_tlast));
            end
            results_seen++;
        end
    end

    // Watchdog: the run is stuck if no handshake happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         quiet_cycles, expected_q.size());
                $display("serial_eeprom_read_master_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset values (64 words, 27-tick delays) for the first
    // command bit; then a short delay is set mid-run and the first dummy
    // bit aborts, so the run stays short.
    task automatic test_reset_defaults();
        repeat (4) drive_tick(1'b0);
        drive_tick(1'b1);
        repeat (60) drive_tick(1'b0);
        write_reg(sem_pkg::CFG_DELAY_TICKS, 8'd1);
        fault_word = 0;
        finish_run();
        fault_word = -1;
    endtask

    // Counts above the ROM size flag an error and stay idle; a zero count
    // does nothing at all.
    task automatic test_count_limits();
        write_reg(sem_pkg::CFG_WORD_COUNT, 8'hC1);    // bit 7 dropped: 65
        drive_tick(1'b1);
        drive_tick(1'b0);
        drive_tick(1'b1);
        write_reg(sem_pkg::CFG_WORD_COUNT, 8'h7F);    // 127
        drive_tick(1'b1);
        drive_tick(1'b1);
        write_reg(sem_pkg::CFG_WORD_COUNT, 8'h80);    // 0
        drive_tick(1'b1);
        drive_tick(1'b0);
        drive_tick(1'b1);
    endtask

    // One word, delay 0 behaving as 1, start held high through busy ticks
    // so back-to-back runs follow; no idling on either side.
    task automatic test_single_word_fast();
        write_reg(sem_pkg::CFG_WORD_COUNT, 8'd1);
        write_reg(sem_pkg::CFG_DELAY_TICKS, 8'd0);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        repeat (113) drive_tick(1'b1);
        finish_run();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    // Nonzero dummy bit on the second word of two aborts the run.
    task automatic test_dummy_abort();
        write_reg(sem_pkg::CFG_WORD_COUNT, 8'd2);
        write_reg(sem_pkg::CFG_DELAY_TICKS, 8'd1);
        fault_word = 1;
        drive_tick(1'b1);
        finish_run();
        fault_word = 0;
        drive_tick(1'b1);        // a fresh start right after the abort
        finish_run();
        fault_word = -1;
    endtask

    // Receiver holds off while items keep coming, so the input backs up;
    // then the sender waits for every result before going on.
    task automatic test_output_stall();
        write_reg(sem_pkg::CFG_WORD_COUNT, 8'd1);
        src_gaps_on = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        drive_tick(1'b1);
        repeat (60) drive_tick(1'b0);
        wait_results_drained();
        src_gaps_on = 1'b1;
        finish_run();
    endtask

    // Longest delay through one full clock-high hold; then a short delay
    // and an abort at the dummy bit keep the rest brief.
    task automatic test_delay_max();
        write_reg(sem_pkg::CFG_WORD_COUNT, 8'd1);
        write_reg(sem_pkg::CFG_DELAY_TICKS, 8'hFF);
        drive_tick(1'b1);
        repeat (260) drive_tick(1'b0);
        write_reg(sem_pkg::CFG_DELAY_TICKS, 8'd1);
        fault_word = 0;
        finish_run();
        fault_word = -1;
    endtask

    // Random settings per phase: short runs with short delays, some zero
    // or oversize counts, a share of broken dummy bits.
    task automatic test_random_runs();
        int   r;
        int   n;
        logic top_bit;
        logic [6:0] wc;
        logic [7:0] dly;
        while (items_sent < TOTAL_ITEMS)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 6)
                wc = 7'd0;
            else if (r < 14)
                wc = 7'($urandom_range(65, 127));
            else
                wc = 7'($urandom_range(1, 2));
            top_bit = 1'($urandom_range(0, 1));
            write_reg(sem_pkg::CFG_WORD_COUNT, {top_bit, wc});
            r = int'($urandom_range(0, 99));
            if (r < 15)
                dly = 8'd0;
            else
                dly = 8'($urandom_range(1, 2));
            write_reg(sem_pkg::CFG_DELAY_TICKS, dly);
            fault_pct    = ($urandom_range(0, 1) == 0) ? 50 : 10;
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            n = int'($urandom_range(5, 30));
            repeat (n) drive_tick($urandom_range(0, 3) == 0);
            finish_run();
        end
        fault_pct    = 0;
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_count_limits();
        test_single_word_fast();
        test_dummy_abort();
        test_output_stall();
        test_delay_max();
        test_random_runs();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered: %0d ticks, %0d results, %0d words read, %0d error flags",
                 items_sent, results_seen, words_presented, errors_flagged);
        $display("covered: %0d register writes, count and delay extremes, back-pressure",
                 reg_writes);
        if (error_count == 0)
            $display("serial_eeprom_read_master_tb: done, clean");
        else
            $display("serial_eeprom_read_master_tb: done, errors");
        $finish;
    end

endmodule
